/* src/sfef_pkg.sv */
// ----------------------------------------------------------------------------
// sfef_pkg
// Shared constants for the spanning forest edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sfef_pkg;

	// width of a vertex number on the request ports
	localparam int unsigned VERTEX_W = 3;

	// highest vertex count that a request can name
	localparam int unsigned VERTEX_SPAN = 1 << VERTEX_W;

	// default vertex count of the graph
	localparam int unsigned NUM_VERTICES_DEF = 8;

endpackage

`default_nettype wire

/* src/spanning_forest_edge_filter.sv */
// ----------------------------------------------------------------------------
// spanning_forest_edge_filter
// Union-find edge filter: walks both endpoints to their roots and links the
// first root under the second endpoint when the roots differ.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block then walks
// parent links from the first endpoint, then from the second, one link per
// cycle through a single lookup unit; each walk reads at most as many links
// as the table depth. An endpoint outside the vertex range skips both walks
// and gives its result with accepted low. Each result shows on accepted,
// edge_from and edge_to for exactly one cycle with done high; the receiver
// cannot stall it, so it must take it then. Setting restart puts every vertex
// back in its own set before that edge is used. The parent table starts out
// as identity after reset, with no clearing pass.
`default_nettype none

module spanning_forest_edge_filter #(
	parameter int unsigned NUM_VERTICES = sfef_pkg::NUM_VERTICES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [sfef_pkg::VERTEX_W-1:0] first_vertex,
	input  wire logic [sfef_pkg::VERTEX_W-1:0] second_vertex,
	input  wire logic                         restart,
	output logic                              done,
	output logic                              accepted,
	output logic [sfef_pkg::VERTEX_W-1:0]     edge_from,
	output logic [sfef_pkg::VERTEX_W-1:0]     edge_to
);

	// only vertices a request can name ever get linked
	localparam int unsigned DEPTH = (NUM_VERTICES < sfef_pkg::VERTEX_SPAN) ?
		NUM_VERTICES : sfef_pkg::VERTEX_SPAN;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned STEP_W = $clog2(DEPTH);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK_A,
		ST_WALK_B
	} state_t;

	state_t                       state_q;
	logic [IDX_W-1:0]             cur_q;
	logic [IDX_W-1:0]             root_a_q;
	logic [STEP_W-1:0]            steps_q;
	logic [DEPTH-1:0]             valid_q;
	logic [IDX_W-1:0]             parent_q [DEPTH];
	logic [sfef_pkg::VERTEX_W-1:0] from_q;
	logic [sfef_pkg::VERTEX_W-1:0] to_q;
	logic                         done_q;
	logic                         accepted_q;

	logic                         take;
	logic                         in_range;
	logic [IDX_W-1:0]             parent_rd;
	logic                         walk_end;
	logic [IDX_W-1:0]             walk_root;

	assign take = start && !busy;
	assign in_range = (int'(first_vertex) < int'(NUM_VERTICES)) &&
		(int'(second_vertex) < int'(NUM_VERTICES));

	// lookup unit: an entry never written reads as its own index
	assign parent_rd = valid_q[cur_q] ? parent_q[cur_q] : cur_q;

	// walk ends at a self link or when the link budget runs out
	assign walk_end = (parent_rd == cur_q) || (steps_q == LAST_STEP);
	assign walk_root = (parent_rd == cur_q) ? cur_q : parent_rd;

	// parent table payload
	always_ff @(posedge clk) begin
		if (state_q == ST_WALK_B && walk_end && walk_root != root_a_q) begin
			parent_q[root_a_q] <= IDX_W'(to_q);
		end
	end

	// sequencer, walk registers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= '0;
			root_a_q   <= '0;
			steps_q    <= '0;
			valid_q    <= '0;
			from_q     <= '0;
			to_q       <= '0;
			done_q     <= 1'b0;
			accepted_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						from_q <= first_vertex;
						to_q   <= second_vertex;
						if (restart) begin
							valid_q <= '0;
						end
						if (in_range) begin
							cur_q   <= IDX_W'(first_vertex);
							steps_q <= '0;
							state_q <= ST_WALK_A;
						end else begin
							accepted_q <= 1'b0;
							done_q     <= 1'b1;
						end
					end
				end
				ST_WALK_A: begin
					if (walk_end) begin
						root_a_q <= walk_root;
						cur_q    <= IDX_W'(to_q);
						steps_q  <= '0;
						state_q  <= ST_WALK_B;
					end else begin
						cur_q   <= parent_rd;
						steps_q <= steps_q + 1'b1;
					end
				end
				ST_WALK_B: begin
					if (walk_end) begin
						if (walk_root != root_a_q) begin
							valid_q[root_a_q] <= 1'b1;
						end
						accepted_q <= (walk_root != root_a_q);
						done_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						cur_q   <= parent_rd;
						steps_q <= steps_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign accepted  = accepted_q;
	assign edge_from = from_q;
	assign edge_to   = to_q;

`ifndef SYNTHESIS
	// a result follows either a request or the end of the second walk
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take) || $past(state_q == ST_WALK_B))
		else $error("result strobe without a request");

	// leaving the walks always delivers a result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("walk finished without a result");

	// a self loop can never be kept
	a_self_loop: assert property (@(posedge clk) disable iff (!arst_n)
		done && accepted |-> edge_from != edge_to)
		else $error("self loop accepted");

	// first walk hands over only to the second walk
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK_A |=> state_q == ST_WALK_A || state_q == ST_WALK_B)
		else $error("first walk left out of order");
`endif

endmodule

`default_nettype wire
